// ----- rtl/core/wbps_pkg.sv -----
// Package for the wildcard byte pattern scanner.
// Holds the configuration register indexes, widths and the shared structs.
// No dependencies.
`timescale 1ns / 1ps

package wbps_pkg;

    // Widths fixed by the register map.
    localparam int SIG_BYTES     = 16;
    localparam int SIG_WORD_W    = 64;
    localparam int CARE_W        = 16;
    localparam int LEN_W         = 5;
    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int RESULT_OFS_W  = 32;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SIGNATURE_LOW    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SIGNATURE_HIGH   = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK        = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SIGNATURE_LENGTH = 4'd3;

    localparam logic [CARE_W-1:0] CARE_MASK_RESET = 16'hFFFF;
    localparam logic [LEN_W-1:0]  LENGTH_RESET    = 5'd1;

    typedef struct packed {
        logic [2*SIG_WORD_W-1:0] signature;  // byte k in bits 8k+7:8k
        logic [CARE_W-1:0]       care_mask;
        logic [LEN_W-1:0]        length;
    } cfg_t;

    typedef struct packed {
        logic             hit;      // masked compare passes over the active length
        logic [LEN_W-1:0] eff_len;  // length after clamping to 1..depth
    } match_t;

endpackage

// ----- rtl/core/wbps_cfg_regs.sv -----
// Configuration register file of the wildcard byte pattern scanner.
// Depends on wbps_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module wbps_cfg_regs
    import wbps_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg_o
);

    logic [SIG_WORD_W-1:0] sig_low_reg;
    logic [SIG_WORD_W-1:0] sig_high_reg;
    logic [CARE_W-1:0]     care_reg;
    logic [LEN_W-1:0]      length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_low_reg  <= '0;
            sig_high_reg <= '0;
            care_reg     <= CARE_MASK_RESET;
            length_reg   <= LENGTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SIGNATURE_LOW:    sig_low_reg  <= cfg_wdata[SIG_WORD_W-1:0];
                REG_SIGNATURE_HIGH:   sig_high_reg <= cfg_wdata[SIG_WORD_W-1:0];
                REG_CARE_MASK:        care_reg     <= cfg_wdata[CARE_W-1:0];
                REG_SIGNATURE_LENGTH: length_reg   <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_o.signature = {sig_high_reg, sig_low_reg};
    assign cfg_o.care_mask = care_reg;
    assign cfg_o.length    = length_reg;

endmodule

// ----- rtl/core/wbps_matcher.sv -----
// Parallel masked compare of the byte window against the signature.
// Depends on wbps_pkg for cfg_t and match_t.
`timescale 1ns / 1ps

module wbps_matcher
    import wbps_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic [DEPTH-1:0][7:0] window_i,  // index 0 is the newest byte
    input  cfg_t                  cfg_i,
    output match_t                match_o
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [LEN_W-1:0] n;
    logic [LEN_W-1:0] idx;
    logic             mismatch;

    always_comb begin
        n = cfg_i.length;
        if (n == '0) begin
            n = LEN_W'(1);
        end
        if (n > LEN_W'(DEPTH)) begin
            n = LEN_W'(DEPTH);
        end
    end

    // Signature byte k lines up with the window byte that arrived n-1-k bytes ago.
    always_comb begin
        mismatch = 1'b0;
        idx      = '0;
        for (int k = 0; k < DEPTH; k++) begin
            idx = n - LEN_W'(1) - LEN_W'(k);
            if ((LEN_W'(k) < n) && cfg_i.care_mask[k]) begin
                if (window_i[idx[IDX_W-1:0]] != cfg_i.signature[8*k +: 8]) begin
                    mismatch = 1'b1;
                end
            end
        end
    end

    assign match_o.hit     = !mismatch;
    assign match_o.eff_len = n;

endmodule

// ----- rtl/core/wildcard_byte_pattern_scanner_unit.sv -----
// Top level of the wildcard byte pattern scanner.
// Depends on wbps_pkg, wbps_cfg_regs and wbps_matcher.
`timescale 1ns / 1ps

// Usage:
// The s_ channel carries one image byte per transfer, with s_end_of_image set
// on the final byte. The m_ channel gives one result per image: m_found=1 and
// the start offset as soon as the first match completes, or m_found=0 with
// offset zero on the final byte when nothing matched. Bytes after a match
// give no result; the final byte clears the image state.
// The configuration port (cfg_wr_en, cfg_index, cfg_wdata) writes one
// register per cycle and is meant to be used only while the block is idle.
// Throughput is one byte per cycle while no held result blocks the input. A
// byte is first captured in the input register, then the window shift, counter
// and masked compare load the result register, which drives m_valid.
// While the receiver stalls, the result waits in the output register; bytes
// that cause no result keep flowing, and the input stalls only when a second
// result is due. Reset clears the byte counter, the reported flag, both
// valids and sets the registers to signature zero, care mask all ones and
// length one.

module wildcard_byte_pattern_scanner_unit
    import wbps_pkg::*;
#(
    parameter int MAX_SIGNATURE_BYTES = 16,
    parameter int OFFSET_BITS         = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_image_byte,
    input  logic                    s_end_of_image,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_found,
    output logic [RESULT_OFS_W-1:0] m_match_offset,
    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int DEPTH = MAX_SIGNATURE_BYTES;

    cfg_t   cfg;
    match_t match;

    // Input register.
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eoi_reg;

    // Image state.
    logic [DEPTH-1:0][7:0]   window_reg;
    logic [DEPTH-1:0][7:0]   window_next;
    logic [OFFSET_BITS-1:0]  seen_reg;
    logic [OFFSET_BITS-1:0]  seen_next;
    logic                    reported_reg;

    // Output register.
    logic                    m_valid_reg;
    logic                    m_found_reg;
    logic [RESULT_OFS_W-1:0] m_offset_reg;

    logic                   enough;
    logic                   match_hit;
    logic                   no_match_end;
    logic                   has_result;
    logic                   out_free;
    logic                   s1_advance;
    logic [OFFSET_BITS-1:0] start_ofs;
    logic [63:0]            start_ofs_ext;

    wbps_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg_o     (cfg)
    );

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) begin
                window_next[i] = s1_byte_reg;
            end else begin
                window_next[i] = window_reg[i-1];
            end
        end
    end

    wbps_matcher #(
        .DEPTH (DEPTH)
    ) u_matcher (
        .window_i (window_next),
        .cfg_i    (cfg),
        .match_o  (match)
    );

    // The byte counter saturates at its maximum.
    assign seen_next     = (seen_reg == '1) ? seen_reg : seen_reg + OFFSET_BITS'(1);
    assign enough        = seen_next >= OFFSET_BITS'(match.eff_len);
    assign match_hit     = !reported_reg && enough && match.hit;
    assign no_match_end  = s1_eoi_reg && !reported_reg && !match_hit;
    assign has_result    = match_hit || no_match_end;
    assign start_ofs     = seen_next - OFFSET_BITS'(match.eff_len);
    assign start_ofs_ext = 64'(start_ofs);

    assign out_free   = !m_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && (!has_result || out_free);
    assign s_ready    = !s1_valid_reg || s1_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_byte_reg <= s_image_byte;
            s1_eoi_reg  <= s_end_of_image;
        end
    end

    // The window needs no clearing: the counter keeps stale bytes out of a match.
    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            window_reg <= window_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end else if (s1_advance) begin
            if (s1_eoi_reg) begin
                seen_reg     <= '0;
                reported_reg <= 1'b0;
            end else begin
                seen_reg     <= seen_next;
                reported_reg <= reported_reg || match_hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance && has_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && has_result) begin
            m_found_reg  <= match_hit;
            m_offset_reg <= match_hit ? start_ofs_ext[RESULT_OFS_W-1:0] : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_match_offset = m_offset_reg;

    // A reported image has always counted at least one byte.
    a_reported_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        reported_reg |-> (seen_reg != '0))
        else $error("reported flag set with an empty byte count");

    // The final byte leaves a clean image state behind.
    a_eoi_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_advance && s1_eoi_reg) |=> (seen_reg == '0) && !reported_reg)
        else $error("image state not cleared after the final byte");

    // A no-match result always carries offset zero.
    a_no_match_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_offset_reg == '0))
        else $error("no-match result with a nonzero offset");

    // The input only stalls behind a held byte that is waiting on the output.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && has_result && m_valid_reg && !m_ready))
        else $error("input stalled without a pending result");

endmodule

// ----- verif/tb_wildcard_byte_pattern_scanner_unit.sv -----
// Self-checking testbench for wildcard_byte_pattern_scanner_unit.
// Runs a directed table and then random images against a built-in scan predictor.
// Depends on wbps_pkg and the scanner RTL.
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_scanner_unit;
    import wbps_pkg::*;

    localparam int TOTAL_ITEMS    = 1350;
    localparam int ITEMS_PER_CFG  = 165;
    localparam int MAX_IMAGE      = 96;
    localparam int DRAIN_CYCLES   = 6;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_IMAGES    = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int NUM_ROWS       = 28;

    typedef struct packed {
        logic                    found;
        logic [RESULT_OFS_W-1:0] offset;
    } scan_result_t;

    // One row is either a register write or one image byte. A typed row
    // carries its expected outcome; the others take it from the predictor.
    typedef struct packed {
        bit                      is_cfg;
        logic [CFG_INDEX_W-1:0]  index;
        logic [CFG_DATA_W-1:0]   data;
        logic [7:0]              image_byte;
        bit                      last;
        bit                      typed;
        bit                      has_result;
        logic                    found;
        logic [RESULT_OFS_W-1:0] offset;
    } dir_row_t;

    logic                    aclk;
    logic                    aresetn        = 1'b0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic [7:0]              s_image_byte   = 8'h00;
    logic                    s_end_of_image = 1'b0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic                    m_found;
    logic [RESULT_OFS_W-1:0] m_match_offset;
    logic                    cfg_wr_en      = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index      = REG_SIGNATURE_LOW;
    logic [CFG_DATA_W-1:0]   cfg_wdata      = '0;

    // Predictor copy of the registers and the per-image state.
    logic [2*SIG_WORD_W-1:0] sig_bytes = '0;
    logic [CARE_W-1:0]       care_bits = CARE_MASK_RESET;
    logic [LEN_W-1:0]        sig_len   = LENGTH_RESET;
    logic [7:0]              window [SIG_BYTES];
    logic [RESULT_OFS_W-1:0] bytes_seen = '0;
    bit                      reported   = 1'b0;

    scan_result_t scan_outcomes [$];
    int           mismatches   = 0;
    int           sent_items   = 0;
    int           stall_cycles = 0;
    bit           steady       = 1'b0;
    bit           hold_go      = 1'b0;
    bit           hold_started = 1'b0;
    int           hold_left    = 0;

    // Item rows use REG_SIGNATURE_LOW as a don't-care index.
    dir_row_t dir_rows [NUM_ROWS] = '{
        // Reset registers: signature byte zero, length one.
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 32'd1},
        // A zero length behaves as length one.
        '{1'b1, REG_SIGNATURE_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b1, REG_SIGNATURE_LOW, 64'h7F, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'h7F, 1'b1, 1'b1, 1'b1, 1'b1, 32'd1},
        // Oversized length clamps to sixteen; with every byte a wildcard the
        // first fifteen bytes must not match against the empty window.
        '{1'b1, REG_SIGNATURE_LENGTH, 64'd31, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b1, REG_CARE_MASK, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'h02, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'h04, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'h08, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'h10, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'h20, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'h40, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'hFE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'hFD, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'hFB, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'hF7, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'hEF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'hDF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'hBF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'h7F, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0},
        // Bytes after a match end the image silently.
        '{1'b0, REG_SIGNATURE_LOW, 64'h0, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0}
    };

    wildcard_byte_pattern_scanner_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_image_byte   (s_image_byte),
        .s_end_of_image (s_end_of_image),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_match_offset (m_match_offset),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int active_length();
        int n;
        n = int'(sig_len);
        if (n < 1)
            n = 1;
        if (n > SIG_BYTES)
            n = SIG_BYTES;
        return n;
    endfunction

    // Advances the image state by one byte and returns the outcome it causes.
    function automatic void scan_byte(input logic [7:0] b, input logic last,
                                      output bit has_result, output scan_result_t res);
        int  n;
        bit  hit;
        n = active_length();
        has_result = 1'b0;
        res = '0;
        for (int i = SIG_BYTES - 1; i > 0; i--)
            window[i] = window[i-1];
        window[0] = b;
        if (bytes_seen != '1)
            bytes_seen = bytes_seen + 1;
        hit = !reported && (bytes_seen >= n);
        for (int k = 0; k < n; k++) begin
            if (care_bits[k] && window[n-1-k] != sig_bytes[8*k +: 8])
                hit = 1'b0;
        end
        if (hit) begin
            has_result = 1'b1;
            res.found = 1'b1;
            res.offset = bytes_seen - RESULT_OFS_W'(n);
            reported = 1'b1;
        end
        if (last) begin
            if (!reported) begin
                has_result = 1'b1;
                res = '0;
            end
            for (int i = 0; i < SIG_BYTES; i++)
                window[i] = 8'h00;
            bytes_seen = '0;
            reported = 1'b0;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                             input bit typed_has, input scan_result_t typed_res);
        int           gap;
        bit           has_result;
        scan_result_t res;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(99) < 23)
                gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_image_byte <= b;
        s_end_of_image <= last;
        do @(posedge aclk); while (!s_ready);
        scan_byte(b, last, has_result, res);
        if (typed) begin
            has_result = typed_has;
            res = typed_res;
        end
        if (has_result)
            scan_outcomes.insert(scan_outcomes.size(), res);
        sent_items++;
    endtask

    // Waits for every outstanding result and lets the pipeline settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (scan_outcomes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SIGNATURE_LOW:    sig_bytes[SIG_WORD_W-1:0] = data;
            REG_SIGNATURE_HIGH:   sig_bytes[2*SIG_WORD_W-1:SIG_WORD_W] = data;
            REG_CARE_MASK:        care_bits = data[CARE_W-1:0];
            REG_SIGNATURE_LENGTH: sig_len = data[LEN_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Most images carry a planted signature instance, some of them with one
    // byte disturbed, in filler drawn partly from the signature's own bytes.
    task automatic send_image();
        logic [7:0] img [MAX_IMAGE];
        int         n;
        int         len;
        int         pos;
        int         k;
        n = active_length();
        if ($urandom_range(99) < 90)
            len = $urandom_range(3 * n + 6, 1);
        else
            len = $urandom_range(MAX_IMAGE, 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(1) == 1)
                img[i] = 8'($urandom_range(255));
            else
                img[i] = sig_bytes[8 * $urandom_range(n - 1, 0) +: 8];
        end
        if (len >= n && $urandom_range(99) < 70) begin
            pos = $urandom_range(len - n, 0);
            for (int j = 0; j < n; j++)
                img[pos+j] = care_bits[j] ? sig_bytes[8*j +: 8] : 8'($urandom_range(255));
            if ($urandom_range(99) < 20) begin
                k = $urandom_range(n - 1, 0);
                img[pos+k] = img[pos+k] ^ (8'h01 << $urandom_range(7));
            end
        end
        for (int i = 0; i < len; i++)
            send_byte(img[i], i == len - 1, 1'b0, 1'b0, '0);
    endtask

    always @(posedge aclk) begin
        if (hold_go && !hold_started) begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 23);
        end
    end

    always @(posedge aclk) begin
        scan_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (scan_outcomes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transfer: expected none, actual %0b/%0d",
                         $time, m_found, m_match_offset);
            end else begin
                want = scan_outcomes.pop_front();
                if (m_found !== want.found) begin
                    mismatches++;
                    $display("%0t: found mismatch: expected %0b, actual %0b",
                             $time, want.found, m_found);
                end
                if (m_match_offset !== want.offset) begin
                    mismatches++;
                    $display("%0t: match_offset mismatch: expected %0d, actual %0d",
                             $time, want.offset, m_match_offset);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_wildcard_byte_pattern_scanner_unit NOT OK");
            $finish;
        end
    end

    initial begin
        int                      phase;
        int                      next_cfg_at;
        logic [SIG_WORD_W-1:0]   lo;
        logic [SIG_WORD_W-1:0]   hi;
        logic [CARE_W-1:0]       mask;
        logic [LEN_W-1:0]        len;
        scan_result_t            typed_res;

        for (int i = 0; i < SIG_BYTES; i++)
            window[i] = 8'h00;
        aresetn <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg) begin
                drain();
                write_reg(dir_rows[r].index, dir_rows[r].data);
            end else begin
                typed_res.found = dir_rows[r].found;
                typed_res.offset = dir_rows[r].offset;
                send_byte(dir_rows[r].image_byte, dir_rows[r].last, dir_rows[r].typed,
                          dir_rows[r].has_result, typed_res);
            end
        end

        phase = 0;
        next_cfg_at = sent_items;
        while (sent_items < TOTAL_ITEMS) begin
            if (sent_items >= next_cfg_at) begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
                mask = 16'($urandom_range(16'hFFFF));
                case (phase % 8)
                    0: begin len = 5'd4;  mask = 16'hFFFF; end
                    1: begin len = 5'd16; mask = 16'hFFFF; lo = '1; hi = '1; end
                    2: len = 5'd0;
                    3: len = 5'd31;
                    4: begin len = 5'd1;  mask = 16'h0000; end
                    5: len = 5'd8;
                    6: begin len = 5'd17; mask = 16'hAAAA; end
                    default: begin len = 5'd12; lo = '0; hi = '0; end
                endcase
                drain();
                write_reg(REG_SIGNATURE_LOW, lo);
                write_reg(REG_SIGNATURE_HIGH, hi);
                write_reg(REG_CARE_MASK, CFG_DATA_W'(mask));
                write_reg(REG_SIGNATURE_LENGTH, CFG_DATA_W'(len));
                // Every single-byte image now yields a result, so a receiver
                // hold-off backs results up and stalls the input.
                if (phase == 4) begin
                    hold_go = 1'b1;
                    repeat (HOLD_IMAGES)
                        send_byte(8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, '0);
                end
                phase++;
                next_cfg_at = sent_items + ITEMS_PER_CFG;
            end
            steady = (sent_items >= 550) && (sent_items < 800);
            send_image();
        end
        steady = 1'b0;

        drain();
        if (mismatches == 0) begin
            $display("tb_wildcard_byte_pattern_scanner_unit OK");
        end else begin
            $display("tb_wildcard_byte_pattern_scanner_unit NOT OK");
        end
        $finish;
    end

endmodule
